[rtl/core/atg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_pkg
// Shared types, codes and constants of the adaptive tolerance error gate.
// ----------------------------------------------------------------------------
package atg_pkg;

  localparam int unsigned COLUMNS        = 256;
  localparam int unsigned COL_BITS       = 8;
  localparam int unsigned DATA_BITS      = 24;
  localparam int unsigned TOL_BITS       = 24;
  localparam int unsigned SUM_BITS_DEF   = 40;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned RATE_BITS      = 17;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned AVG_BITS       = 42;
  localparam int unsigned TGT_BITS       = 44;
  localparam int unsigned TGT_LO_BITS    = 22;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 24;

  localparam logic [RATE_BITS-1:0] ONE_Q16 = RATE_BITS'(65536);
  localparam logic [63:0]          HALF_LSB = 64'd32768;

  localparam logic [1:0] ACT_ELEM     = 2'd0;
  localparam logic [1:0] ACT_FINALIZE = 2'd1;
  localparam logic [1:0] ACT_RESTART  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TOL      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TOL      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_TOL     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOL_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ADAPT_RATE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE_FLAGS   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLASS_CUTOFF = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELEM,
    ST_FIN_RD,
    ST_FIN_LAT,
    ST_FIN_DIV,
    ST_FIN_M1,
    ST_FIN_M2,
    ST_FIN_M3,
    ST_FIN_WB,
    ST_CLR,
    ST_RESTART
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : atg_pkg
`default_nettype wire

[rtl/core/atg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_in_if
// Request channel carrying one error element or action into the gate.
// ----------------------------------------------------------------------------
interface atg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [atg_pkg::COL_BITS-1:0]         column;
  logic signed [atg_pkg::DATA_BITS-1:0] prediction;
  logic signed [atg_pkg::DATA_BITS-1:0] target_value;
  logic signed [atg_pkg::DATA_BITS-1:0] error_in;
  logic                                 last_of_feature;

  modport source (output valid, action, column, prediction, target_value, error_in,
                  last_of_feature, input ready);
  modport sink   (input valid, action, column, prediction, target_value, error_in,
                  last_of_feature, output ready);
endinterface : atg_in_if
`default_nettype wire

[rtl/core/atg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_out_if
// Result channel carrying one gated error or action acknowledge.
// ----------------------------------------------------------------------------
interface atg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [atg_pkg::COL_BITS-1:0]         column_out;
  logic signed [atg_pkg::DATA_BITS-1:0] adjusted_error;
  logic                                 feature_end;
  logic                                 backprop_needed;
  logic                                 round_done;

  modport source (output valid, column_out, adjusted_error, feature_end, backprop_needed,
                  round_done, input ready);
  modport sink   (input valid, column_out, adjusted_error, feature_end, backprop_needed,
                  round_done, output ready);
endinterface : atg_out_if
`default_nettype wire

[rtl/core/adaptive_tolerance_error_gate_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_tolerance_error_gate_core
// Gates training errors per column against adaptive per-column tolerances.
// ----------------------------------------------------------------------------
// An element request reads the column's tolerance and accumulator from the
// on-chip memories in the accept cycle; in the following cycle the updated
// accumulator is written back and the gated error is placed in the output
// register. A new request is taken only when the output register is empty,
// so the next request waits until the previous result has been taken. A
// finalize request walks the first min(column_count, 256) columns; each
// column passes through a memory read, a memory latency state, a bit-serial
// divide, the partial products for the blend in ST_FIN_M1, ST_FIN_M2 and
// ST_FIN_M3, and a write-back that stores the new tolerance and clears the
// accumulator; the accumulators of the columns that remain are then cleared.
// A restart request sweeps all 256 columns. After reset the same sweep
// loads the tolerances and clears the accumulators before the first
// request is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module adaptive_tolerance_error_gate_core #(
  parameter int unsigned SUM_BITS   = atg_pkg::SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = atg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  atg_in_if.sink                                     in_i,
  atg_out_if.source                                  out_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [atg_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [atg_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i
);

  localparam int unsigned ACC_BITS = SUM_BITS + COUNT_BITS;
  localparam int unsigned QW = (SUM_BITS > atg_pkg::AVG_BITS) ? SUM_BITS : atg_pkg::AVG_BITS;
  localparam logic [QW-1:0] AVG_CAP = QW'(1) << (atg_pkg::AVG_BITS - 1);
  localparam int unsigned TB = atg_pkg::TGT_BITS;
  localparam int unsigned LB = atg_pkg::TGT_LO_BITS;
  localparam int unsigned HB = TB - LB;
  localparam int unsigned RB = atg_pkg::RATE_BITS;
  localparam int unsigned DB = atg_pkg::DATA_BITS;
  localparam int unsigned CB = atg_pkg::COL_BITS;

  // Configuration registers.
  logic [8:0]           col_count_q;
  logic [22:0]          min_tol_q, max_tol_q, init_tol_q;
  logic signed [23:0]   tol_off_q;
  logic [RB-1:0]        rate_cfg_q;
  logic [1:0]           mode_q;
  logic signed [23:0]   cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= 9'd256;
      min_tol_q   <= '0;
      max_tol_q   <= '0;
      init_tol_q  <= '0;
      tol_off_q   <= 24'sd65536;
      rate_cfg_q  <= RB'(32768);
      mode_q      <= '0;
      cutoff_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        atg_pkg::CFG_COLUMN_COUNT: col_count_q <= cfg_wdata_i[8:0];
        atg_pkg::CFG_MIN_TOL:      min_tol_q   <= cfg_wdata_i[22:0];
        atg_pkg::CFG_MAX_TOL:      max_tol_q   <= cfg_wdata_i[22:0];
        atg_pkg::CFG_INIT_TOL:     init_tol_q  <= cfg_wdata_i[22:0];
        atg_pkg::CFG_TOL_OFFSET:   tol_off_q   <= $signed(cfg_wdata_i[23:0]);
        atg_pkg::CFG_ADAPT_RATE:   rate_cfg_q  <= cfg_wdata_i[RB-1:0];
        atg_pkg::CFG_MODE_FLAGS:   mode_q      <= cfg_wdata_i[1:0];
        atg_pkg::CFG_CLASS_CUTOFF: cutoff_q    <= $signed(cfg_wdata_i[23:0]);
        default: ;
      endcase
    end
  end

  // Control state.
  atg_pkg::state_e state_q, state_d;
  logic [8:0]      cnt_q, cnt_d;
  logic            emit_q, emit_d;
  logic            feat_q, feat_d;
  logic            ov_q, ov_d;

  // Latched request and finalize datapath registers.
  logic [CB-1:0]         col_q;
  logic signed [DB-1:0]  pred_q, targ_q, err_q;
  logic                  last_q;
  logic                  cnt_zero_q;
  logic [23:0]           tolf_q;
  logic signed [TB-1:0]  tgt_q, tgt_d;
  logic [LB+RB-1:0]      plo_q;
  logic signed [HB+RB:0] phi_q;
  logic [23+RB:0]        ptol_q;

  // Result register payload.
  logic [CB-1:0]         o_col_q, o_col_d;
  logic signed [DB-1:0]  o_err_q, o_err_d;
  logic                  o_end_q, o_end_d;
  logic                  o_bp_q, o_bp_d;
  logic                  o_done_q, o_done_d;
  logic                  o_load;

  // Memory and divider connections.
  logic                rd_en;
  logic [CB-1:0]       rd_addr, wr_addr;
  logic                tol_we, acc_we;
  logic [23:0]         tol_wdata, tol_rdata;
  logic [ACC_BITS-1:0] acc_wdata, acc_rdata;
  logic                div_start;
  atg_pkg::div_stat_t  div_stat;
  logic [SUM_BITS-1:0] div_quo;

  atg_store #(.ACC_BITS(ACC_BITS)) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .tol_we_i   (tol_we),
    .tol_wdata_i(tol_wdata),
    .acc_we_i   (acc_we),
    .acc_wdata_i(acc_wdata),
    .tol_rdata_o(tol_rdata),
    .acc_rdata_o(acc_rdata)
  );

  atg_div #(.SUM_BITS(SUM_BITS), .COUNT_BITS(COUNT_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_rdata[ACC_BITS-1:COUNT_BITS]),
    .divisor_i (acc_rdata[COUNT_BITS-1:0]),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  // Derived configuration values.
  logic [8:0]    n_cols;
  logic [RB-1:0] rate, rate_inv;
  logic [23:0]   restart_tol;

  assign n_cols      = (col_count_q > 9'd256) ? 9'd256 : col_count_q;
  assign rate        = (rate_cfg_q > atg_pkg::ONE_Q16) ? atg_pkg::ONE_Q16 : rate_cfg_q;
  assign rate_inv    = atg_pkg::ONE_Q16 - rate;
  assign restart_tol = {1'b0, (init_tol_q > min_tol_q) ? init_tol_q : min_tol_q};

  // Element gating datapath, fed by the latched request and the memory read.
  logic [SUM_BITS-1:0]   sum_r;
  logic [COUNT_BITS-1:0  ] cntv_r;
  logic                  v_t, v_p, v_ge, cls_zero;
  logic signed [DB-1:0]  er1;
  logic [DB-1:0]         mag;
  logic [SUM_BITS:0]     sum_add;
  logic [SUM_BITS-1:0]   sum_new;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  over;
  logic signed [DB-1:0]  er_out;
  logic                  exc;

  always_comb begin
    sum_r    = acc_rdata[ACC_BITS-1:COUNT_BITS];
    cntv_r   = acc_rdata[COUNT_BITS-1:0];
    v_t      = targ_q > cutoff_q;
    v_p      = pred_q > cutoff_q;
    v_ge     = pred_q >= targ_q;
    // With mode bit 1, same side of the cutoff with the prediction farther out (or equal, above it): no error.
    cls_zero = mode_q[1] && ((!v_t && !v_p && !v_ge) || (v_t && v_p && v_ge));
    er1      = cls_zero ? '0 : err_q;
    mag      = er1[DB-1] ? DB'(-er1) : DB'(er1);
    sum_add  = {1'b0, sum_r} + (SUM_BITS+1)'(mag);
    sum_new  = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
    cnt_new  = (&cntv_r) ? cntv_r : cntv_r + COUNT_BITS'(1);
    over     = mag > tol_rdata;
    if (!over) begin
      er_out = '0;
    end else if (mode_q[0]) begin
      er_out = er1[DB-1] ? er1 + $signed(tol_rdata) : er1 - $signed(tol_rdata);
    end else begin
      er_out = er1;
    end
    exc = feat_q | over;
  end

  // Finalize datapath: average, blend, round and clamp.
  logic [QW-1:0]                  q_ext;
  logic [atg_pkg::AVG_BITS-1:0]   avg;
  logic signed [63:0]             blend, rnd;
  logic [47:0]                    r48;
  logic [23:0]                    tol_new;

  always_comb begin
    q_ext = QW'(div_quo);
    if (cnt_zero_q) begin
      avg = '0;
    end else if (q_ext > AVG_CAP) begin
      avg = AVG_CAP[atg_pkg::AVG_BITS-1:0];
    end else begin
      avg = q_ext[atg_pkg::AVG_BITS-1:0];
    end
    tgt_d = $signed({{(TB - atg_pkg::AVG_BITS){1'b0}}, avg})
          + $signed({{(TB - 24){tol_off_q[23]}}, tol_off_q});
    blend = ($signed({{(64 - HB - RB - 1){phi_q[HB+RB]}}, phi_q}) <<< LB)
          + $signed({{(64 - LB - RB){1'b0}}, plo_q})
          + $signed({{(64 - 24 - RB){1'b0}}, ptol_q});
    rnd   = blend + $signed(atg_pkg::HALF_LSB);
    r48   = rnd[63:atg_pkg::FRAC_BITS];
    if (blend[63]) begin
      r48 = '0;
    end
    if (r48 > {25'd0, max_tol_q}) begin
      r48 = {25'd0, max_tol_q};
    end
    if (r48 < {25'd0, min_tol_q}) begin
      r48 = {25'd0, min_tol_q};
    end
    tol_new = r48[23:0];
  end

  // Sequencer: next state, memory controls and result loading.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    feat_d    = feat_q;
    ov_d      = ov_q;
    rd_en     = 1'b0;
    rd_addr   = in_i.column;
    wr_addr   = cnt_q[CB-1:0];
    tol_we    = 1'b0;
    tol_wdata = restart_tol;
    acc_we    = 1'b0;
    acc_wdata = '0;
    div_start = 1'b0;
    o_load    = 1'b0;
    o_col_d   = '0;
    o_err_d   = '0;
    o_end_d   = 1'b0;
    o_bp_d    = 1'b0;
    o_done_d  = 1'b1;
    in_i.ready = (state_q == atg_pkg::ST_IDLE) && !ov_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      atg_pkg::ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          case (in_i.action)
            atg_pkg::ACT_ELEM: begin
              rd_en   = 1'b1;
              state_d = atg_pkg::ST_ELEM;
            end
            atg_pkg::ACT_FINALIZE: begin
              cnt_d   = '0;
              state_d = (n_cols == 9'd0) ? atg_pkg::ST_CLR : atg_pkg::ST_FIN_RD;
            end
            atg_pkg::ACT_RESTART: begin
              cnt_d   = '0;
              emit_d  = 1'b1;
              state_d = atg_pkg::ST_RESTART;
            end
            default: ;
          endcase
        end
      end
      atg_pkg::ST_ELEM: begin
        wr_addr   = col_q;
        acc_we    = 1'b1;
        acc_wdata = {sum_new, cnt_new};
        o_load    = 1'b1;
        o_col_d   = col_q;
        o_err_d   = er_out;
        o_end_d   = last_q;
        o_bp_d    = exc;
        o_done_d  = 1'b0;
        ov_d      = 1'b1;
        feat_d    = last_q ? 1'b0 : exc;
        state_d   = atg_pkg::ST_IDLE;
      end
      atg_pkg::ST_FIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_q[CB-1:0];
        state_d = atg_pkg::ST_FIN_LAT;
      end
      atg_pkg::ST_FIN_LAT: begin
        div_start = 1'b1;
        state_d   = atg_pkg::ST_FIN_DIV;
      end
      atg_pkg::ST_FIN_DIV: begin
        if (div_stat.done) begin
          state_d = atg_pkg::ST_FIN_M1;
        end
      end
      atg_pkg::ST_FIN_M1: begin
        state_d = atg_pkg::ST_FIN_M2;
      end
      atg_pkg::ST_FIN_M2: begin
        state_d = atg_pkg::ST_FIN_M3;
      end
      atg_pkg::ST_FIN_M3: begin
        state_d = atg_pkg::ST_FIN_WB;
      end
      atg_pkg::ST_FIN_WB: begin
        tol_we    = 1'b1;
        tol_wdata = tol_new;
        acc_we    = 1'b1;
        cnt_d     = cnt_q + 9'd1;
        if (cnt_q == 9'd255) begin
          o_load  = 1'b1;
          ov_d    = 1'b1;
          state_d = atg_pkg::ST_IDLE;
        end else if (cnt_q + 9'd1 >= n_cols) begin
          state_d = atg_pkg::ST_CLR;
        end else begin
          state_d = atg_pkg::ST_FIN_RD;
        end
      end
      atg_pkg::ST_CLR: begin
        acc_we = 1'b1;
        cnt_d  = cnt_q + 9'd1;
        if (cnt_q[CB-1:0] == '1) begin
          o_load  = 1'b1;
          ov_d    = 1'b1;
          state_d = atg_pkg::ST_IDLE;
        end
      end
      atg_pkg::ST_RESTART: begin
        tol_we = 1'b1;
        acc_we = 1'b1;
        cnt_d  = cnt_q + 9'd1;
        if (cnt_q[CB-1:0] == '1) begin
          o_load  = emit_q;
          ov_d    = emit_q;
          emit_d  = 1'b0;
          state_d = atg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atg_pkg::ST_RESTART;
      cnt_q   <= '0;
      emit_q  <= 1'b0;
      feat_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      feat_q  <= feat_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers: request latch, finalize pipeline and result.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      col_q  <= in_i.column;
      pred_q <= in_i.prediction;
      targ_q <= in_i.target_value;
      err_q  <= in_i.error_in;
      last_q <= in_i.last_of_feature;
    end
    if (state_q == atg_pkg::ST_FIN_LAT) begin
      cnt_zero_q <= (acc_rdata[COUNT_BITS-1:0] == '0);
      tolf_q     <= tol_rdata;
    end
    if ((state_q == atg_pkg::ST_FIN_DIV) && div_stat.done) begin
      tgt_q <= tgt_d;
    end
    if (state_q == atg_pkg::ST_FIN_M1) begin
      plo_q <= tgt_q[LB-1:0] * rate;
    end
    if (state_q == atg_pkg::ST_FIN_M2) begin
      phi_q <= $signed(tgt_q[TB-1:LB]) * $signed({1'b0, rate});
    end
    if (state_q == atg_pkg::ST_FIN_M3) begin
      ptol_q <= tolf_q * rate_inv;
    end
    if (o_load) begin
      o_col_q  <= o_col_d;
      o_err_q  <= o_err_d;
      o_end_q  <= o_end_d;
      o_bp_q   <= o_bp_d;
      o_done_q <= o_done_d;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.column_out      = o_col_q;
  assign out_o.adjusted_error  = o_err_q;
  assign out_o.feature_end     = o_end_q;
  assign out_o.backprop_needed = o_bp_q;
  assign out_o.round_done      = o_done_q;

endmodule : adaptive_tolerance_error_gate_core
`default_nettype wire

[rtl/core/atg_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_store
// Per-column tolerance memory and accumulator memory, registered read.
// ----------------------------------------------------------------------------
module atg_store #(
  parameter int unsigned ACC_BITS = atg_pkg::SUM_BITS_DEF + atg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rd_en_i,
  input  wire logic [atg_pkg::COL_BITS-1:0]        rd_addr_i,
  input  wire logic [atg_pkg::COL_BITS-1:0]        wr_addr_i,
  input  wire logic                                tol_we_i,
  input  wire logic [atg_pkg::TOL_BITS-1:0]        tol_wdata_i,
  input  wire logic                                acc_we_i,
  input  wire logic [ACC_BITS-1:0]                 acc_wdata_i,
  output logic      [atg_pkg::TOL_BITS-1:0]        tol_rdata_o,
  output logic      [ACC_BITS-1:0]                 acc_rdata_o
);

  logic [atg_pkg::TOL_BITS-1:0] tol_mem [atg_pkg::COLUMNS];
  logic [ACC_BITS-1:0]          acc_mem [atg_pkg::COLUMNS];

  always_ff @(posedge clk_i) begin
    if (tol_we_i) begin
      tol_mem[wr_addr_i] <= tol_wdata_i;
    end
    if (rd_en_i) begin
      tol_rdata_o <= tol_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we_i) begin
      acc_mem[wr_addr_i] <= acc_wdata_i;
    end
    if (rd_en_i) begin
      acc_rdata_o <= acc_mem[rd_addr_i];
    end
  end

endmodule : atg_store
`default_nettype wire

[rtl/core/atg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atg_div #(
  parameter int unsigned SUM_BITS   = atg_pkg::SUM_BITS_DEF,
  parameter int unsigned COUNT_BITS = atg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SUM_BITS-1:0]    dividend_i,
  input  wire logic [COUNT_BITS-1:0]  divisor_i,
  output atg_pkg::div_stat_t          stat_o,
  output logic      [SUM_BITS-1:0]    quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(SUM_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [COUNT_BITS:0]   rem_q, rem_d;
  logic [SUM_BITS-1:0]   quo_q, quo_d;
  logic [COUNT_BITS-1:0] dsr_q, dsr_d;
  logic [COUNT_BITS:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[COUNT_BITS-1:0], quo_q[SUM_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(SUM_BITS);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sh - {1'b0, dsr_q};
        quo_d = {quo_q[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[SUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule : atg_div
`default_nettype wire
